FILE: hw/rtl/spfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the servo packet framer.
package spfc_pkg;

    // Operation codes carried on the operation input.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Packet header and instruction codes.
    localparam logic [7:0] HDR_A      = 8'hFF;
    localparam logic [7:0] HDR_B      = 8'hFD;
    localparam logic [7:0] HDR_ZERO   = 8'h00;
    localparam logic [7:0] INST_WRITE = 8'h03;
    localparam logic [7:0] INST_READ  = 8'h02;
    localparam logic [7:0] LEN_ONE    = 8'h06;
    localparam logic [7:0] LEN_TWO    = 8'h07;

    // CRC-16 generator polynomial, MSB first, no reflection.
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Byte position within the packet.
    localparam int unsigned POS_W = 4;
    typedef logic [POS_W-1:0] spfc_pos_t;

    // Position of the final byte for one and for two parameter bytes.
    localparam spfc_pos_t POS_LAST_ONE = 4'd12;
    localparam spfc_pos_t POS_LAST_TWO = 4'd13;

    // Controller to datapath commands.
    typedef struct packed {
        logic start;   // latch a new request and restart the packet
        logic step;    // load the next packet byte into the output register
    } spfc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_full;  // output register holds a byte not yet taken
        logic at_last;   // current position is the closing CRC byte
    } spfc_status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } spfc_state_t;

    // Fold one byte into the CRC, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/spfc_ctrl.sv
// Controller state machine that sequences the bytes of one instruction packet.
module spfc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  out_stall,
    input  spfc_pkg::spfc_status_t status,
    output spfc_pkg::spfc_cmd_t    cmd
);
    import spfc_pkg::*;

    spfc_state_t state_reg;
    spfc_state_t state_next;
    logic        load_ok;
    logic        step_en;
    logic        done;
    logic        accept;

    // A byte may move into the output register when it is empty or being drained.
    assign load_ok = !status.out_full || !out_stall;

    always_comb
    begin
        step_en = 1'b0;
        case (state_reg)
            ST_IDLE: step_en = 1'b0;
            ST_SEND: step_en = load_ok;
            default: step_en = 1'b0;
        endcase
    end

    // The next request is taken in the cycle the closing byte is loaded.
    assign done      = step_en && status.at_last;
    assign in_stall  = !((state_reg == ST_IDLE) || done);
    assign accept    = in_valid && !in_stall;
    assign cmd.start = accept;
    assign cmd.step  = step_en;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (accept)
                begin
                    state_next = ST_SEND;
                end
                else if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/spfc_dp.sv
// Datapath: request holding registers, byte position, CRC register and output register.
module spfc_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spfc_pkg::spfc_cmd_t    cmd,
    output spfc_pkg::spfc_status_t status,
    input  logic                   operation,
    input  logic [7:0]             target_id,
    input  logic [15:0]            reg_address,
    input  logic [1:0]             param_bytes,
    input  logic [15:0]            param_value,
    output logic [7:0]             frame_byte,
    output logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_stall
);
    import spfc_pkg::*;

    // Held request fields.
    logic        op_reg;
    logic [7:0]  id_reg;
    logic [15:0] addr_reg;
    logic        two_reg;
    logic [15:0] val_reg;

    // Sequencing and checksum state.
    spfc_pos_t   pos_reg;
    spfc_pos_t   pos_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  frame_byte_reg;
    logic        last_byte_reg;

    logic [7:0]  cur_byte;
    spfc_pos_t   pos_last;
    logic        is_data;
    logic        at_last;

    // The closing position depends on the parameter byte count.
    assign pos_last = two_reg ? POS_LAST_TWO : POS_LAST_ONE;
    assign at_last  = (pos_reg == pos_last);
    assign is_data  = (pos_reg < (pos_last - 4'd1));

    // Select the byte at the current position.
    always_comb
    begin
        case (pos_reg)
            4'd0:    cur_byte = HDR_A;
            4'd1:    cur_byte = HDR_A;
            4'd2:    cur_byte = HDR_B;
            4'd3:    cur_byte = HDR_ZERO;
            4'd4:    cur_byte = id_reg;
            4'd5:    cur_byte = two_reg ? LEN_TWO : LEN_ONE;
            4'd6:    cur_byte = HDR_ZERO;
            4'd7:    cur_byte = (op_reg == OP_READ) ? INST_READ : INST_WRITE;
            4'd8:    cur_byte = addr_reg[7:0];
            4'd9:    cur_byte = addr_reg[15:8];
            4'd10:   cur_byte = val_reg[7:0];
            4'd11:   cur_byte = two_reg ? val_reg[15:8] : crc_reg[7:0];
            4'd12:   cur_byte = two_reg ? crc_reg[7:0] : crc_reg[15:8];
            4'd13:   cur_byte = crc_reg[15:8];
            default: cur_byte = HDR_ZERO;
        endcase
    end

    // Position steps per loaded byte, CRC per non-CRC byte; a request restarts both.
    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (cmd.start)
        begin
            pos_next = '0;
            crc_next = CRC_INIT;
        end
        else if (cmd.step)
        begin
            pos_next = pos_reg + 4'd1;
            if (is_data)
            begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end
        end
    end

    // Output register fills on a step and empties when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (cmd.start)
        begin
            op_reg   <= operation;
            id_reg   <= target_id;
            addr_reg <= reg_address;
            two_reg  <= param_bytes[1];
            val_reg  <= param_value;
        end
        if (cmd.step)
        begin
            frame_byte_reg <= cur_byte;
            last_byte_reg  <= at_last;
        end
    end

    assign status.out_full = out_valid_reg;
    assign status.at_last  = at_last;
    assign out_valid       = out_valid_reg;
    assign frame_byte      = frame_byte_reg;
    assign last_byte       = last_byte_reg;

endmodule

FILE: hw/rtl/servo_packet_framer_crc16_core.sv
// Top level of the servo instruction packet framer with CRC-16.
//
// Input channel: one servo command per request (operation, target_id,
// reg_address, param_bytes, param_value) on in_valid / in_stall.
// Output channel: the packet, one byte per request, on frame_byte with
// last_byte marking the CRC high byte that closes it; out_valid / out_stall.
// A packet is 13 bytes for one parameter byte and 14 for two; param_bytes
// of 0 counts as one and 3 as two.
// The first byte is loaded into the output register once the controller
// has entered the send state. With no output stall, one byte leaves per
// cycle and a new command is taken in the cycle the closing byte is
// loaded, so a command is accepted once per packet.
// The CRC register folds in each loaded byte ahead of the CRC bytes.
// While the receiver stalls, the output register holds its byte and the
// sequence pauses; in_stall stays high until the closing byte is loaded.
// Reset clears the controller to idle and empties the output register.
module servo_packet_framer_crc16_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  target_id,
    input  logic [15:0] reg_address,
    input  logic [1:0]  param_bytes,
    input  logic [15:0] param_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);
    import spfc_pkg::*;

    spfc_cmd_t    cmd;
    spfc_status_t status;

    // Sequencer.
    spfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Byte selection, checksum and output register.
    spfc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .operation   (operation),
        .target_id   (target_id),
        .reg_address (reg_address),
        .param_bytes (param_bytes),
        .param_value (param_value),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    // A freshly taken request keeps the input side busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a new request");

    // Loading the closing position presents a marked last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.at_last) |=> (out_valid && last_byte))
        else $error("closing byte not marked as last");

    // Any other loaded byte is not marked as last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !status.at_last) |=> (out_valid && !last_byte))
        else $error("inner byte marked as last");

endmodule
